### hw/rtl/mf5_pkg.sv
// ----------------------------------------------------------------------------
// mf5_pkg
// shared constants, control struct and counting helper for the 5x5 median
// ----------------------------------------------------------------------------
package mf5_pkg;

	localparam int ROWS      = 5;
	localparam int COLS      = 5;
	localparam int HIST_COLS = COLS - 1;
	localparam int WIN_TAPS  = ROWS * COLS;
	localparam int CNT_W     = $clog2(WIN_TAPS + 1);

	localparam logic [CNT_W-1:0] WIN_RANK = CNT_W'((WIN_TAPS - 1) / 2);

	typedef struct packed {
		logic valid;
		logic row_end;
	} mf5_ctl_t;

	// ones count over the window, a column group at a time
	function automatic logic [CNT_W-1:0] mf5_popcount(input logic [WIN_TAPS-1:0] bits);
		logic [CNT_W-1:0] part [COLS];
		logic [CNT_W-1:0] total;
		total = '0;
		for (int g = 0; g < COLS; g++) begin
			part[g] = '0;
			for (int j = 0; j < ROWS; j++) begin
				part[g] = part[g] + CNT_W'(bits[g*ROWS + j]);
			end
		end
		for (int g = 0; g < COLS; g++) begin
			total = total + part[g];
		end
		return total;
	endfunction

endpackage

### hw/rtl/median_filter_5x5.sv
// ----------------------------------------------------------------------------
// median_filter_5x5
// streaming 5x5 median over a row, fed one pixel column per beat
//
//   channel  handshake            payload
//   col      col_valid/col_stall  pixel_up2..pixel_down2, final_column
//   res      res_valid/res_stall  median_value, row_end
//
// one column beat per cycle unless stalled; a final column holds col_stall
// in ST_FLUSH1 and ST_FLUSH2 while flush columns pass through the window cells
// a result passes stages s1 to s4 after the beat that completes its window
// reset clears the window cells, the column count and the rank pipeline
// res_stall back-pressures the rank stages; empty stages still take beats
// ----------------------------------------------------------------------------
module median_filter_5x5
	import mf5_pkg::*;
#(
	parameter int PIXEL_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   col_valid,
	output logic                   col_stall,
	input  logic [PIXEL_WIDTH-1:0] pixel_up2,
	input  logic [PIXEL_WIDTH-1:0] pixel_up1,
	input  logic [PIXEL_WIDTH-1:0] pixel_mid,
	input  logic [PIXEL_WIDTH-1:0] pixel_down1,
	input  logic [PIXEL_WIDTH-1:0] pixel_down2,
	input  logic                   final_column,
	output logic                   res_valid,
	input  logic                   res_stall,
	output logic [PIXEL_WIDTH-1:0] median_value,
	output logic                   row_end
);

	localparam logic [1:0] ST_RUN    = 2'd0;
	localparam logic [1:0] ST_FLUSH1 = 2'd1;
	localparam logic [1:0] ST_FLUSH2 = 2'd2;

	localparam logic [1:0] SEEN_FULL = 2'd2;

	logic [1:0]             state_q;
	logic [1:0]             seen_q;
	logic                   flush_one_q;

	logic                   job_stall;
	logic                   col_acc;
	logic                   shift;
	logic                   clear;
	mf5_ctl_t               job_ctl;
	logic [PIXEL_WIDTH-1:0] in_col   [ROWS];
	logic [PIXEL_WIDTH-1:0] feed_col [ROWS];
	logic [PIXEL_WIDTH-1:0] cell_in  [HIST_COLS][ROWS];
	logic [PIXEL_WIDTH-1:0] cell_col [HIST_COLS][ROWS];
	logic [PIXEL_WIDTH-1:0] job_pix  [WIN_TAPS];

	assign in_col[0] = pixel_up2;
	assign in_col[1] = pixel_up1;
	assign in_col[2] = pixel_mid;
	assign in_col[3] = pixel_down1;
	assign in_col[4] = pixel_down2;

	assign col_stall = (state_q != ST_RUN) || job_stall;
	assign col_acc   = col_valid && !col_stall;

	// zero columns stand in for the right border during a flush
	always_comb begin
		for (int r = 0; r < ROWS; r++) begin
			feed_col[r] = (state_q == ST_RUN) ? in_col[r] : '0;
		end
	end

	always_comb begin
		for (int k = 0; k < HIST_COLS; k++) begin
			for (int r = 0; r < ROWS; r++) begin
				cell_in[k][r] = (k == HIST_COLS - 1) ? feed_col[r] : cell_col[(k + 1) % HIST_COLS][r];
			end
		end
		for (int c = 0; c < COLS; c++) begin
			for (int r = 0; r < ROWS; r++) begin
				job_pix[c*ROWS + r] = (c < HIST_COLS) ? cell_col[c % HIST_COLS][r] : feed_col[r];
			end
		end
	end

	always_comb begin
		shift           = 1'b0;
		clear           = 1'b0;
		job_ctl.valid   = 1'b0;
		job_ctl.row_end = 1'b0;
		case (state_q)
			ST_RUN: begin
				shift         = col_acc;
				job_ctl.valid = col_acc && (seen_q == SEEN_FULL);
			end
			ST_FLUSH1: begin
				shift         = !job_stall;
				job_ctl.valid = flush_one_q;
			end
			ST_FLUSH2: begin
				clear           = !job_stall;
				job_ctl.valid   = 1'b1;
				job_ctl.row_end = 1'b1;
			end
			default: begin
				shift = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			seen_q      <= '0;
			flush_one_q <= 1'b0;
		end else begin
			case (state_q)
				ST_RUN: begin
					if (col_acc) begin
						if (final_column) begin
							state_q     <= ST_FLUSH1;
							flush_one_q <= (seen_q != 2'd0);
							seen_q      <= '0;
						end else if (seen_q != SEEN_FULL) begin
							seen_q <= seen_q + 2'd1;
						end
					end
				end
				ST_FLUSH1: begin
					if (!job_stall) state_q <= ST_FLUSH2;
				end
				ST_FLUSH2: begin
					if (!job_stall) state_q <= ST_RUN;
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	for (genvar k = 0; k < HIST_COLS; k++) begin : g_cell
		mf5_col_cell #(
			.PIXEL_WIDTH(PIXEL_WIDTH)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.clear  (clear),
			.col_in (cell_in[k]),
			.col_q  (cell_col[k])
		);
	end

	mf5_rank_sel #(
		.PIXEL_WIDTH(PIXEL_WIDTH)
	) u_rank (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_ctl      (job_ctl),
		.job_pix      (job_pix),
		.job_stall    (job_stall),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.median_value (median_value),
		.row_end      (row_end)
	);

endmodule

### hw/rtl/mf5_col_cell.sv
// ----------------------------------------------------------------------------
// mf5_col_cell
// one window column of five pixels: load col_in on shift, zero on clear
// ----------------------------------------------------------------------------
module mf5_col_cell
	import mf5_pkg::*;
#(
	parameter int PIXEL_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   shift,
	input  logic                   clear,
	input  logic [PIXEL_WIDTH-1:0] col_in [ROWS],
	output logic [PIXEL_WIDTH-1:0] col_q  [ROWS]
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROWS; r++) begin
				col_q[r] <= '0;
			end
		end else if (clear) begin
			for (int r = 0; r < ROWS; r++) begin
				col_q[r] <= '0;
			end
		end else if (shift) begin
			for (int r = 0; r < ROWS; r++) begin
				col_q[r] <= col_in[r];
			end
		end
	end

endmodule

### hw/rtl/mf5_rank_sel.sv
// ----------------------------------------------------------------------------
// mf5_rank_sel
// rank pipeline: pairwise compare, rank count, pick the 13th smallest
// ----------------------------------------------------------------------------
module mf5_rank_sel
	import mf5_pkg::*;
#(
	parameter int PIXEL_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mf5_ctl_t               job_ctl,
	input  logic [PIXEL_WIDTH-1:0] job_pix [WIN_TAPS],
	output logic                   job_stall,
	output logic                   res_valid,
	input  logic                   res_stall,
	output logic [PIXEL_WIDTH-1:0] median_value,
	output logic                   row_end
);

	logic                   valid_s1, valid_s2, valid_s3, valid_s4;
	logic                   ready1, ready2, ready3, ready4;
	logic                   re_s1, re_s2, re_s3, re_s4;
	logic [PIXEL_WIDTH-1:0] v_s1 [WIN_TAPS];
	logic [PIXEL_WIDTH-1:0] v_s2 [WIN_TAPS];
	logic [PIXEL_WIDTH-1:0] v_s3 [WIN_TAPS];
	logic [WIN_TAPS-1:0]    lt_s2 [WIN_TAPS];
	logic [WIN_TAPS-1:0]    sel_s3;
	logic [PIXEL_WIDTH-1:0] median_s4;

	logic [WIN_TAPS-1:0]    lt_d  [WIN_TAPS];
	logic [WIN_TAPS-1:0]    gt_d  [WIN_TAPS];
	logic [WIN_TAPS-1:0]    sel_d;
	logic [PIXEL_WIDTH-1:0] grp_d [COLS];
	logic [PIXEL_WIDTH-1:0] median_d;

	assign ready4    = !valid_s4 || !res_stall;
	assign ready3    = !valid_s3 || ready4;
	assign ready2    = !valid_s2 || ready3;
	assign ready1    = !valid_s1 || ready2;
	assign job_stall = !ready1;

	// lt_d[i][j]: tap j lies strictly below tap i
	always_comb begin
		for (int i = 0; i < WIN_TAPS; i++) begin
			for (int j = 0; j < WIN_TAPS; j++) begin
				lt_d[i][j] = v_s1[j] < v_s1[i];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < WIN_TAPS; i++) begin
			for (int j = 0; j < WIN_TAPS; j++) begin
				gt_d[i][j] = lt_s2[j][i];
			end
		end
		for (int i = 0; i < WIN_TAPS; i++) begin
			sel_d[i] = (mf5_popcount(lt_s2[i]) <= WIN_RANK) &&
			           (mf5_popcount(gt_d[i]) <= WIN_RANK);
		end
	end

	// every selected tap holds the median, so an or of them is exact
	always_comb begin
		median_d = '0;
		for (int g = 0; g < COLS; g++) begin
			grp_d[g] = '0;
			for (int j = 0; j < ROWS; j++) begin
				grp_d[g] = grp_d[g] | (v_s3[g*ROWS + j] & {PIXEL_WIDTH{sel_s3[g*ROWS + j]}});
			end
		end
		for (int g = 0; g < COLS; g++) begin
			median_d = median_d | grp_d[g];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready1) valid_s1 <= job_ctl.valid;
			if (ready2) valid_s2 <= valid_s1;
			if (ready3) valid_s3 <= valid_s2;
			if (ready4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ready1) begin
			re_s1 <= job_ctl.row_end;
			for (int i = 0; i < WIN_TAPS; i++) begin
				v_s1[i] <= job_pix[i];
			end
		end
		if (ready2) begin
			re_s2 <= re_s1;
			for (int i = 0; i < WIN_TAPS; i++) begin
				v_s2[i]  <= v_s1[i];
				lt_s2[i] <= lt_d[i];
			end
		end
		if (ready3) begin
			re_s3  <= re_s2;
			sel_s3 <= sel_d;
			for (int i = 0; i < WIN_TAPS; i++) begin
				v_s3[i] <= v_s2[i];
			end
		end
		if (ready4) begin
			re_s4     <= re_s3;
			median_s4 <= median_d;
		end
	end

	assign res_valid    = valid_s4;
	assign median_value = median_s4;
	assign row_end      = re_s4;

endmodule

### hw/rtl/mf5_checker.sv
// ----------------------------------------------------------------------------
// mf5_checker
// port-level checks on column flush and result beats of the median filter
// ----------------------------------------------------------------------------
module mf5_checker
	import mf5_pkg::*;
#(
	parameter int PIXEL_WIDTH = 16
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   col_valid,
	input logic                   col_stall,
	input logic                   final_column,
	input logic                   res_valid,
	input logic                   res_stall,
	input logic [PIXEL_WIDTH-1:0] median_value,
	input logic                   row_end
);

	// flush of a row end holds col_stall after the final column beat
	a_flush_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(col_valid && !col_stall && final_column) |=> col_stall ##1 col_stall)
		else $error("column beat taken during row-end flush");

	// after an ordinary column beat, a free result side never stalls columns
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(!res_stall && $past(col_valid && !col_stall && !final_column)) |-> !col_stall)
		else $error("column stalled with result side free");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> (res_valid && $stable(median_value) && $stable(row_end)))
		else $error("stalled result beat changed");

endmodule

bind median_filter_5x5 mf5_checker #(.PIXEL_WIDTH(PIXEL_WIDTH)) u_mf5_checker (.*);

### tb/median_filter_5x5_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_filter_5x5_chk
// window predictor and result checker for the 5x5 median filter
//
// watches the column and result channels; every accepted column beat moves
// a private copy of the window and queues the medians it completes, every
// accepted result beat is compared against the oldest queued median
// ----------------------------------------------------------------------------
module median_filter_5x5_chk
	import mf5_pkg::*;
#(
	parameter int PIXEL_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   col_valid,
	input  logic                   col_stall,
	input  logic [PIXEL_WIDTH-1:0] pixel_up2,
	input  logic [PIXEL_WIDTH-1:0] pixel_up1,
	input  logic [PIXEL_WIDTH-1:0] pixel_mid,
	input  logic [PIXEL_WIDTH-1:0] pixel_down1,
	input  logic [PIXEL_WIDTH-1:0] pixel_down2,
	input  logic                   final_column,
	input  logic                   res_valid,
	input  logic                   res_stall,
	input  logic [PIXEL_WIDTH-1:0] median_value,
	input  logic                   row_end,
	output int                     fail_count,
	output int                     pending
);

	typedef logic [PIXEL_WIDTH-1:0] pix_t;
	typedef logic [ROWS-1:0][PIXEL_WIDTH-1:0] column_t;
	typedef column_t [COLS+1:0] span_t;

	typedef struct packed {
		pix_t median;
		logic row_end;
	} median_res_t;

	column_t     history [HIST_COLS];
	logic [1:0]  cols_taken;
	median_res_t medians_due [$];
	int          mismatch_total = 0;

	assign fail_count = mismatch_total;

	// 13th smallest of the five columns starting at first
	function automatic pix_t window_median(input span_t span, input int first);
		pix_t vals [WIN_TAPS];
		pix_t tmp;
		int   n;
		int   k;
		n = 0;
		for (int c = 0; c < COLS; c++) begin
			for (int r = 0; r < ROWS; r++) begin
				vals[n] = span[first + c][r];
				n = n + 1;
			end
		end
		for (int i = 1; i < WIN_TAPS; i++) begin
			tmp = vals[i];
			k = i;
			while (k > 0 && vals[k-1] > tmp) begin
				vals[k] = vals[k-1];
				k = k - 1;
			end
			vals[k] = tmp;
		end
		return vals[WIN_RANK];
	endfunction

	task automatic advance_window(input column_t incoming, input logic last);
		span_t       span;
		median_res_t due;
		int          first;
		span = '0;
		for (int c = 0; c < HIST_COLS; c++) begin
			span[c] = history[c];
		end
		span[HIST_COLS] = incoming;
		if (!last) begin
			if (cols_taken >= 2) begin
				due.median  = window_median(span, 0);
				due.row_end = 1'b0;
				medians_due.push_back(due);
			end
			for (int c = 0; c < HIST_COLS; c++) begin
				history[c] = span[c+1];
			end
			if (cols_taken < 2) begin
				cols_taken = cols_taken + 2'd1;
			end
		end else begin
			// flush the centres still owed, zeros to the right
			first = (cols_taken >= 2) ? 0 : ((cols_taken == 1) ? 1 : 2);
			for (int s = first; s <= 2; s++) begin
				due.median  = window_median(span, s);
				due.row_end = (s == 2);
				medians_due.push_back(due);
			end
			for (int c = 0; c < HIST_COLS; c++) begin
				history[c] = '0;
			end
			cols_taken = '0;
		end
	endtask

	task automatic check_median;
		median_res_t due;
		if (medians_due.size() == 0) begin
			$error("unexpected result beat: median_value=%0h row_end=%0b",
				median_value, row_end);
			mismatch_total++;
		end else begin
			due = medians_due.pop_front();
			if (median_value !== due.median) begin
				$error("median_value: expected %0h, got %0h", due.median, median_value);
				mismatch_total++;
			end
			if (row_end !== due.row_end) begin
				$error("row_end: expected %0b, got %0b", due.row_end, row_end);
				mismatch_total++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < HIST_COLS; c++) begin
				history[c] = '0;
			end
			cols_taken = '0;
			medians_due.delete();
			pending <= 0;
		end else begin
			if (col_valid && !col_stall) begin
				advance_window({pixel_down2, pixel_down1, pixel_mid, pixel_up1, pixel_up2},
					final_column);
			end
			if (res_valid && !res_stall) begin
				check_median();
			end
			pending <= medians_due.size();
		end
	end

endmodule

### tb/tb_median_filter_5x5.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_median_filter_5x5
// stimulus and verdict for the streaming 5x5 median filter
//
// feeds rows of pixel columns: a directed set of border and extreme rows,
// then random rows in three idling phases (sender light / receiver heavy,
// the reverse, then none), with one long receiver hold-off to fill the
// pipeline and drains between phases; checking sits in the checker module
// ----------------------------------------------------------------------------
module tb_median_filter_5x5;

	localparam int PIXEL_WIDTH = 16;
	localparam int PHASE_ITEMS = 130;
	localparam int HOLD_CYCLES = 80;
	localparam int TAIL_CYCLES = 20;

	typedef logic [4:0][PIXEL_WIDTH-1:0] column_t;

	logic                   clk          = 1'b0;
	logic                   arst_n       = 1'b0;
	logic                   col_valid    = 1'b0;
	logic                   col_stall;
	logic [PIXEL_WIDTH-1:0] pixel_up2    = '0;
	logic [PIXEL_WIDTH-1:0] pixel_up1    = '0;
	logic [PIXEL_WIDTH-1:0] pixel_mid    = '0;
	logic [PIXEL_WIDTH-1:0] pixel_down1  = '0;
	logic [PIXEL_WIDTH-1:0] pixel_down2  = '0;
	logic                   final_column = 1'b0;
	logic                   res_valid;
	logic                   res_stall    = 1'b1;
	logic [PIXEL_WIDTH-1:0] median_value;
	logic                   row_end;

	int fail_count;
	int pending;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_req      = 0;
	int hold_done     = 0;
	int hold_left     = 0;
	int columns_sent  = 0;

	median_filter_5x5 #(
		.PIXEL_WIDTH(PIXEL_WIDTH)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.col_valid   (col_valid),
		.col_stall   (col_stall),
		.pixel_up2   (pixel_up2),
		.pixel_up1   (pixel_up1),
		.pixel_mid   (pixel_mid),
		.pixel_down1 (pixel_down1),
		.pixel_down2 (pixel_down2),
		.final_column(final_column),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.median_value(median_value),
		.row_end     (row_end)
	);

	median_filter_5x5_chk #(
		.PIXEL_WIDTH(PIXEL_WIDTH)
	) u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.col_valid   (col_valid),
		.col_stall   (col_stall),
		.pixel_up2   (pixel_up2),
		.pixel_up1   (pixel_up1),
		.pixel_mid   (pixel_mid),
		.pixel_down1 (pixel_down1),
		.pixel_down2 (pixel_down2),
		.final_column(final_column),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.median_value(median_value),
		.row_end     (row_end),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	always #6 clk = ~clk;

	// result side: random stalls, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_left > 0) begin
			res_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else if (hold_req != hold_done) begin
			hold_done = hold_req;
			hold_left = HOLD_CYCLES - 1;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	task automatic send_column(input column_t px, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			col_valid <= 1'b0;
			@(posedge clk);
		end
		col_valid    <= 1'b1;
		pixel_up2    <= px[0];
		pixel_up1    <= px[1];
		pixel_mid    <= px[2];
		pixel_down1  <= px[3];
		pixel_down2  <= px[4];
		final_column <= last;
		do @(posedge clk); while (col_stall);
		columns_sent++;
	endtask

	task automatic send_flat_row(input int len, input logic [PIXEL_WIDTH-1:0] value);
		column_t px;
		for (int i = 0; i < len; i++) begin
			px = {5{value}};
			send_column(px, i == len - 1);
		end
	endtask

	task automatic drain_results;
		col_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		col_valid     <= 1'b0;
		send_idle_pct <= send_pct;
		recv_idle_pct <= recv_pct;
		@(posedge clk);
	endtask

	function automatic logic [PIXEL_WIDTH-1:0] pick_pixel(input int mode);
		case (mode)
			0:       return PIXEL_WIDTH'($urandom);
			1:       return PIXEL_WIDTH'($urandom_range(7));
			2:       return ($urandom_range(1) != 0) ? '1 : '0;
			default: return PIXEL_WIDTH'(16'h8000 + $urandom_range(15) - 8);
		endcase
	endfunction

	task automatic send_random_row;
		column_t    px;
		logic [4:0] off_frame;
		int         len;
		int         mode;
		len  = ($urandom_range(9) < 8) ? $urandom_range(1, 10) : $urandom_range(11, 40);
		mode = $urandom_range(3);
		// rows above or below the frame come in as zero
		off_frame = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'b0;
		for (int i = 0; i < len; i++) begin
			for (int r = 0; r < 5; r++) begin
				px[r] = off_frame[r] ? '0 : pick_pixel(mode);
			end
			send_column(px, i == len - 1);
		end
	endtask

	task automatic run_phase(input int goal);
		while (columns_sent < goal) begin
			send_random_row();
		end
	endtask

	initial begin
		column_t px;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		set_idling(20, 79);

		// rows of one, two and four columns at full scale
		send_flat_row(1, '1);
		send_flat_row(2, '1);
		send_flat_row(4, '1);
		// rising columns
		for (int i = 0; i < 6; i++) begin
			for (int r = 0; r < 5; r++) begin
				px[r] = PIXEL_WIDTH'(i * 10000 + r * 1000);
			end
			send_column(px, i == 5);
		end
		// alternating bit patterns
		for (int i = 0; i < 5; i++) begin
			px = (i % 2 == 0) ? {5{16'h5555}} : {5{16'hAAAA}};
			send_column(px, i == 4);
		end
		// bright centre row in an otherwise dark window
		for (int i = 0; i < 3; i++) begin
			px = '0;
			px[2] = '1;
			send_column(px, i == 2);
		end
		drain_results();

		run_phase(PHASE_ITEMS);
		drain_results();

		set_idling(79, 20);
		run_phase(2 * PHASE_ITEMS);
		drain_results();

		set_idling(0, 0);
		hold_req <= hold_req + 1;
		run_phase(3 * PHASE_ITEMS);
		drain_results();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#3_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
